[design/iacht_pkg.sv]
// Package for the in-array chained hash table unit: status codes, opcodes,
// sequencer states, relink sequences and default sizes. No dependencies.
package iacht_pkg;

   localparam int unsigned DefaultSlots   = 256;
   localparam int unsigned DefaultKeyBits = 32;
   localparam int unsigned TableSizeBits  = 9;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_FIND   = 2'd1,
      OP_REMOVE = 2'd2,
      OP_UNUSED = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_PRESENT  = 3'd1,
      ST_FULL     = 3'd2,
      ST_BADKEY   = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic [4:0] {
      S_CLEAR,      // rebuild free list, one slot per cycle
      S_IDLE,
      S_MOD,        // bucket = hash mod table_size, one bit per cycle
      S_RD_HOME,    // issue reads of the home slot
      S_HOME,       // home slot data valid
      S_WALK_RD,    // issue reads of the walk slot
      S_WALK,       // walk slot data valid
      S_FREE_RD,    // read free list head
      S_FREE,       // free head index valid; read its neighbours
      S_FREE2,      // neighbours valid
      S_RELINK,     // write steps
      S_RESP
   } state_type;

   typedef enum logic [2:0] {
      MODE_HOME_FREE,    // home slot was free
      MODE_APPEND,       // append a free slot to the home chain
      MODE_MOVE_FOREIGN, // move a foreign entry out of the home slot
      MODE_HEAD_REFILL,  // remove the head, refill it from its successor
      MODE_UNLINK_ENTRY, // remove an entry behind the head
      MODE_LONE_HEAD     // remove a head that has no successor
   } relink_mode_type;

endpackage

[design/iacht_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM with registered read.
// Depends on nothing.
module iacht_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[design/iacht_mod.sv]
// Restoring divider that yields hash_code modulo table_size, one bit per cycle.
// Depends on iacht_pkg.
module iacht_mod import iacht_pkg::*; #(
   parameter int unsigned SIZE_BITS = 9
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [31:0]          dividend,
   input  logic [SIZE_BITS-1:0] divisor,
   output logic                 done,
   output logic [SIZE_BITS-1:0] remainder
);
   logic [31:0]          quo_ff, quo_in;
   logic [SIZE_BITS:0]   rem_ff, rem_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic [SIZE_BITS+1:0] trial;

   assign trial = {rem_ff, quo_ff[31]} - {2'b00, divisor};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[30:0], 1'b0};
         if (!trial[SIZE_BITS+1]) begin
            rem_in = trial[SIZE_BITS:0];
         end else begin
            rem_in = {rem_ff[SIZE_BITS-1:0], quo_ff[31]};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   // The last step's remainder is formed combinationally from the registers and the trial subtraction.
   assign done      = busy_ff && (cnt_ff == 6'd1);
   assign remainder = trial[SIZE_BITS+1] ? {rem_ff[SIZE_BITS-2:0], quo_ff[31]}
                                         : trial[SIZE_BITS-1:0];
endmodule

[design/in_array_chained_hash_table_unit.sv]
// Hash table with separate chaining held inside one slot array.
// A request runs the serial modulo, reads the home slot and walks the chain
// one entry at a time; an insert or remove that relinks adds write steps,
// and a bad key goes straight to the result.
// One transaction in flight; the next is taken once the result is accepted.
// Reset, and every write of table_size, runs a clearing pass over every slot
// and the list head that rebuilds the free list; no transaction is taken meanwhile.
// Depends on iacht_pkg, iacht_ram and iacht_mod.
module in_array_chained_hash_table_unit import iacht_pkg::*; #(
   parameter int unsigned SLOTS    = DefaultSlots,
   parameter int unsigned KEY_BITS = DefaultKeyBits
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_opcode,
   input  logic                     req_key_present,
   input  logic [31:0]              req_key_value,
   input  logic [31:0]              req_hash_code,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [2:0]               rsp_status,
   output logic [31:0]              rsp_stored_key,
   input  logic                     csr_write_enable,
   input  logic [TableSizeBits-1:0] csr_write_data
);
   localparam int unsigned IB = $clog2(SLOTS);     // slot index bits
   localparam int unsigned LB = $clog2(SLOTS + 1); // link index bits
   localparam int unsigned SB = LB;                // table size bits
   localparam int unsigned EB = 1 + IB + KEY_BITS; // used, bucket, key
   localparam logic [LB-1:0] HeadPos = LB'(SLOTS);

   // Entry memory: {used, bucket, key}; link memories next and prev.
   logic          ew_en;
   logic [LB-1:0] ew_a_l;
   logic [EB-1:0] ew_d, er_d;
   logic [LB-1:0] er_a_l;
   logic          nw_en, pw_en;
   logic [LB-1:0] nw_a, nw_d, pw_a, pw_d, nr_a, pr_a, nr_d, pr_d;

   iacht_ram #(.WIDTH(EB), .DEPTH(SLOTS)) u_entry (
      .clock, .wr_en(ew_en), .wr_addr(ew_a_l[IB-1:0]), .wr_data(ew_d),
      .rd_addr(er_a_l[IB-1:0]), .rd_data(er_d));
   iacht_ram #(.WIDTH(LB), .DEPTH(SLOTS + 1)) u_next (
      .clock, .wr_en(nw_en), .wr_addr(nw_a), .wr_data(nw_d),
      .rd_addr(nr_a), .rd_data(nr_d));
   iacht_ram #(.WIDTH(LB), .DEPTH(SLOTS + 1)) u_prev (
      .clock, .wr_en(pw_en), .wr_addr(pw_a), .wr_data(pw_d),
      .rd_addr(pr_a), .rd_data(pr_d));

   wire            e_used   = er_d[EB-1];
   wire [IB-1:0]   e_bucket = er_d[KEY_BITS +: IB];
   wire [KEY_BITS-1:0] e_key = er_d[KEY_BITS-1:0];

   state_type            state_ff, state_in;
   logic [SB-1:0]        size_ff, size_in;
   logic [LB-1:0]        clr_ff, clr_in;
   logic [1:0]           op_ff, op_in;
   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic [31:0]          hash_ff, hash_in;
   logic [LB-1:0]        b_ff, b_in;       // home slot
   logic [LB-1:0]        e_ff, e_in;       // walk slot
   logic [LB-1:0]        f_ff, f_in;       // free slot taken
   logic [LB-1:0]        bn_ff, bn_in, bp_ff, bp_in; // home links
   logic [LB-1:0]        fn_ff, fn_in, fp_ff, fp_in;
   logic [EB-1:0]        home_ff, home_in; // home entry copy
   logic [KEY_BITS-1:0]  hit_ff, hit_in;
   logic [3:0]           step_ff, step_in;
   logic [LB-1:0]        cnt_ff, cnt_in;
   logic [2:0]           st_ff, st_in;
   logic [31:0]          rk_ff, rk_in;
   logic                 rv_ff, rv_in;
   logic                 mod_start, mod_done;
   logic [TableSizeBits-1:0] mod_rem;
   logic [KEY_BITS-1:0]  kin;

   // Relinking sequence chosen once the lookup is done.
   relink_mode_type mode_ff, mode_in;

   iacht_mod #(.SIZE_BITS(TableSizeBits)) u_mod (
      .clock, .reset, .start(mod_start), .dividend(hash_in),
      .divisor(TableSizeBits'(size_ff)),
      .done(mod_done), .remainder(mod_rem));

   assign kin = KEY_BITS'(req_key_value);

   logic [SB-1:0] csr_clamped;
   always_comb begin
      if (32'(csr_write_data) > SLOTS) csr_clamped = SB'(SLOTS);
      else csr_clamped = SB'(csr_write_data);
   end

   always_comb begin
      state_in = state_ff; size_in = size_ff; clr_in = clr_ff;
      op_in = op_ff; key_in = key_ff; hash_in = hash_ff;
      b_in = b_ff; e_in = e_ff; f_in = f_ff; bn_in = bn_ff; bp_in = bp_ff;
      fn_in = fn_ff; fp_in = fp_ff; home_in = home_ff; hit_in = hit_ff;
      step_in = step_ff; cnt_in = cnt_ff; st_in = st_ff; rk_in = rk_ff;
      rv_in = rv_ff; mode_in = mode_ff;
      mod_start = 1'b0; req_ready = 1'b0;
      ew_en = 1'b0; ew_a_l = b_ff; ew_d = '0; er_a_l = b_ff;
      nw_en = 1'b0; nw_a = HeadPos; nw_d = HeadPos;
      pw_en = 1'b0; pw_a = HeadPos; pw_d = HeadPos;
      nr_a = b_ff; pr_a = b_ff;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            // Slots below table_size are linked in descending order behind the
            // head, so the highest slot sits first on the free list.
            ew_en = (clr_ff != HeadPos); ew_a_l = clr_ff; ew_d = '0;
            nw_en = 1'b1; pw_en = 1'b1; nw_a = clr_ff; pw_a = clr_ff;
            if (clr_ff == HeadPos) begin
               nw_d = (size_ff == '0) ? HeadPos : LB'(size_ff) - LB'(1);
               pw_d = (size_ff == '0) ? HeadPos : '0;
               state_in = S_IDLE;
            end else begin
               nw_d = (clr_ff == '0) ? HeadPos : clr_ff - LB'(1);
               pw_d = (LB'(clr_ff) + LB'(1) >= LB'(size_ff)) ? HeadPos
                      : clr_ff + LB'(1);
               nw_en = (clr_ff < LB'(size_ff)); pw_en = nw_en;
               clr_in = (clr_ff + LB'(1) >= LB'(SLOTS)) ? HeadPos : clr_ff + LB'(1);
            end
         end
         S_IDLE: begin
            req_ready = !rv_ff;
            if (req_valid && req_ready) begin
               op_in = req_opcode; key_in = kin; hash_in = req_hash_code;
               if (!req_key_present || size_ff == '0 || req_opcode == OP_UNUSED) begin
                  st_in = ST_BADKEY; rk_in = '0; state_in = S_RESP;
               end else begin
                  state_in = S_MOD; mod_start = 1'b1;
               end
            end
         end
         S_MOD: begin
            if (mod_done) begin
               b_in = LB'(mod_rem);
               state_in = S_RD_HOME;
            end
         end
         S_RD_HOME: begin
            er_a_l = b_ff; nr_a = b_ff; pr_a = b_ff;
            state_in = S_HOME;
         end
         S_HOME: begin
            home_in = er_d; bn_in = nr_d; bp_in = pr_d;
            e_in = b_ff; cnt_in = '0; f_in = HeadPos;
            if (!e_used) begin
               if (op_ff == OP_INSERT) begin
                  mode_in = MODE_HOME_FREE; step_in = '0; state_in = S_RELINK;
               end else begin
                  st_in = ST_NOTFOUND; rk_in = '0; state_in = S_RESP;
               end
            end else if (LB'(e_bucket) != b_ff) begin
               if (op_ff == OP_INSERT) begin
                  mode_in = MODE_MOVE_FOREIGN; state_in = S_FREE_RD;
               end else begin
                  st_in = ST_NOTFOUND; rk_in = '0; state_in = S_RESP;
               end
            end else begin
               state_in = S_WALK;
            end
         end
         S_WALK_RD: begin
            er_a_l = e_ff; nr_a = e_ff; pr_a = e_ff;
            state_in = S_WALK;
         end
         S_WALK: begin
            // Entry at e_ff is valid in er_d/nr_d/pr_d here.
            if (e_key == key_ff) begin
               hit_in = e_key;
               if (op_ff == OP_INSERT) begin
                  st_in = ST_PRESENT; rk_in = '0; state_in = S_RESP;
               end else if (op_ff == OP_FIND) begin
                  st_in = ST_OK; rk_in = 32'(e_key); state_in = S_RESP;
               end else begin
                  st_in = ST_OK; rk_in = 32'(e_key);
                  fn_in = nr_d; fp_in = pr_d; step_in = '0;
                  if (e_ff == b_ff && nr_d != b_ff) begin
                     mode_in = MODE_HEAD_REFILL; f_in = nr_d;
                     er_a_l = nr_d; nr_a = nr_d; // read successor
                  end else if (e_ff == b_ff) begin
                     mode_in = MODE_LONE_HEAD;
                  end else begin
                     mode_in = MODE_UNLINK_ENTRY;
                  end
                  state_in = S_RELINK;
               end
            end else if (nr_d == b_ff || cnt_ff == LB'(SLOTS - 1)) begin
               if (op_ff == OP_INSERT) begin
                  mode_in = MODE_APPEND; state_in = S_FREE_RD;
               end else begin
                  st_in = ST_NOTFOUND; rk_in = '0; state_in = S_RESP;
               end
            end else begin
               e_in = nr_d; cnt_in = cnt_ff + LB'(1);
               state_in = S_WALK_RD;
            end
         end
         S_FREE_RD: begin
            nr_a = HeadPos;
            state_in = S_FREE;
         end
         S_FREE: begin
            if (nr_d == HeadPos) begin
               st_in = ST_FULL; rk_in = '0; state_in = S_RESP;
            end else begin
               f_in = nr_d; nr_a = nr_d; pr_a = nr_d;
               state_in = S_FREE2;
            end
         end
         S_FREE2: begin
            fn_in = nr_d; fp_in = pr_d; step_in = '0;
            state_in = S_RELINK;
         end
         S_RELINK: begin
            step_in = step_ff + 4'd1;
            st_in = ST_OK;
            case (mode_ff)
               MODE_HOME_FREE: begin
                  // home slot was free: unlink it, make a one-entry chain
                  case (step_ff)
                     4'd0: begin
                        nw_en = 1'b1; nw_a = bp_ff; nw_d = bn_ff;
                        pw_en = 1'b1; pw_a = bn_ff; pw_d = bp_ff;
                     end
                     default: begin
                        nw_en = 1'b1; nw_a = b_ff; nw_d = b_ff;
                        pw_en = 1'b1; pw_a = b_ff; pw_d = b_ff;
                        ew_en = 1'b1; ew_a_l = b_ff;
                        ew_d = {1'b1, b_ff[IB-1:0], key_ff};
                        rk_in = '0; state_in = S_RESP;
                     end
                  endcase
               end
               MODE_APPEND: begin
                  // append taken free slot f before the head
                  case (step_ff)
                     4'd0: begin
                        nw_en = 1'b1; nw_a = fp_ff; nw_d = fn_ff;
                        pw_en = 1'b1; pw_a = fn_ff; pw_d = fp_ff;
                     end
                     4'd1: begin
                        nw_en = 1'b1; nw_a = bp_ff; nw_d = f_ff;
                        pw_en = 1'b1; pw_a = b_ff; pw_d = f_ff;
                     end
                     default: begin
                        nw_en = 1'b1; nw_a = f_ff; nw_d = b_ff;
                        pw_en = 1'b1; pw_a = f_ff; pw_d = bp_ff;
                        ew_en = 1'b1; ew_a_l = f_ff;
                        ew_d = {1'b1, b_ff[IB-1:0], key_ff};
                        rk_in = '0; state_in = S_RESP;
                     end
                  endcase
               end
               MODE_MOVE_FOREIGN: begin
                  // move foreign entry from b to f. bn/bp may be f's old
                  // neighbours or b itself; resolve after the free unlink.
                  case (step_ff)
                     4'd0: begin
                        nw_en = 1'b1; nw_a = fp_ff; nw_d = fn_ff;
                        pw_en = 1'b1; pw_a = fn_ff; pw_d = fp_ff;
                     end
                     4'd1: begin
                        nw_en = 1'b1; nw_a = f_ff;
                        nw_d = (bn_ff == b_ff) ? f_ff : bn_ff;
                        pw_en = 1'b1; pw_a = f_ff;
                        pw_d = (bp_ff == b_ff) ? f_ff : bp_ff;
                     end
                     4'd2: begin
                        nw_en = (bp_ff != b_ff); nw_a = bp_ff; nw_d = f_ff;
                        pw_en = (bn_ff != b_ff); pw_a = bn_ff; pw_d = f_ff;
                        ew_en = 1'b1; ew_a_l = f_ff; ew_d = home_ff;
                     end
                     default: begin
                        nw_en = 1'b1; nw_a = b_ff; nw_d = b_ff;
                        pw_en = 1'b1; pw_a = b_ff; pw_d = b_ff;
                        ew_en = 1'b1; ew_a_l = b_ff;
                        ew_d = {1'b1, b_ff[IB-1:0], key_ff};
                        rk_in = '0; state_in = S_RESP;
                     end
                  endcase
               end
               MODE_HEAD_REFILL: begin
                  // head refill from successor d = f_ff; er_d/nr_d hold d
                  case (step_ff)
                     4'd0: begin
                        hit_in = e_key; fn_in = nr_d;
                     end
                     4'd1: begin
                        ew_en = 1'b1; ew_a_l = b_ff;
                        ew_d = {1'b1, b_ff[IB-1:0], hit_ff};
                        nw_en = 1'b1; nw_a = b_ff; nw_d = fn_ff;
                        pw_en = 1'b1; pw_a = fn_ff; pw_d = b_ff;
                        er_a_l = HeadPos; nr_a = HeadPos;
                     end
                     4'd2: begin
                        fp_in = nr_d; // old free head
                        ew_en = 1'b1; ew_a_l = f_ff; ew_d = '0;
                     end
                     default: begin
                        nw_en = 1'b1; nw_a = HeadPos; nw_d = f_ff;
                        pw_en = 1'b1; pw_a = fp_ff; pw_d = f_ff;
                        if (step_ff == 4'd3) begin
                           step_in = 4'd4;
                        end else begin
                           nw_a = f_ff; nw_d = fp_ff;
                           pw_a = f_ff; pw_d = HeadPos;
                           state_in = S_RESP;
                        end
                     end
                  endcase
               end
               default: begin
                  // unlink e (non-head only) and put it on the free list
                  case (step_ff)
                     4'd0: begin
                        nw_en = (mode_ff == MODE_UNLINK_ENTRY);
                        nw_a = fp_ff; nw_d = fn_ff;
                        pw_en = (mode_ff == MODE_UNLINK_ENTRY);
                        pw_a = fn_ff; pw_d = fp_ff;
                        nr_a = HeadPos;
                     end
                     4'd1: begin
                        bn_in = nr_d; // old free head
                        ew_en = 1'b1; ew_a_l = e_ff; ew_d = '0;
                     end
                     4'd2: begin
                        nw_en = 1'b1; nw_a = HeadPos; nw_d = e_ff;
                        pw_en = 1'b1; pw_a = bn_ff; pw_d = e_ff;
                     end
                     default: begin
                        nw_en = 1'b1; nw_a = e_ff; nw_d = bn_ff;
                        pw_en = 1'b1; pw_a = e_ff; pw_d = HeadPos;
                        state_in = S_RESP;
                     end
                  endcase
               end
            endcase
         end
         S_RESP: begin
            if (!rv_ff) begin
               rv_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (csr_write_enable) begin
         size_in = csr_clamped; clr_in = '0; state_in = S_CLEAR;
      end
   end

   // In refill mode step 0 must capture the successor's read data.
   // (The read is issued in S_WALK on the cycle of the hit.)

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         size_ff  <= (SLOTS < 256) ? SB'(SLOTS) : SB'(256);
         clr_ff   <= '0;
         rv_ff    <= 1'b0;
         step_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         size_ff  <= size_in;
         clr_ff   <= clr_in;
         rv_ff    <= rv_in;
         step_ff  <= step_in;
         cnt_ff   <= cnt_in;
      end
      op_ff <= op_in; key_ff <= key_in; hash_ff <= hash_in;
      b_ff <= b_in; e_ff <= e_in; f_ff <= f_in; bn_ff <= bn_in; bp_ff <= bp_in;
      fn_ff <= fn_in; fp_ff <= fp_in; home_ff <= home_in; hit_ff <= hit_in;
      st_ff <= st_in; rk_ff <= rk_in; mode_ff <= mode_in;
   end

   assign rsp_valid      = rv_ff;
   assign rsp_status     = st_ff;
   assign rsp_stored_key = rk_ff;
endmodule

[design/iacht_checker.sv]
// Port-level checker for the in-array chained hash table unit, bound to the top.
// Depends on iacht_pkg.
module iacht_checker import iacht_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [31:0] rsp_stored_key,
   input logic        csr_write_enable
);
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= ST_NOTFOUND))
      else $error("status out of range");
   a_key_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_stored_key == 32'd0)
      else $error("stored key nonzero on failure");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("transaction accepted while result pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("result dropped");
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> !req_ready)
      else $error("accept during clearing pass");
endmodule

bind in_array_chained_hash_table_unit iacht_checker u_iacht_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_status, .rsp_stored_key, .csr_write_enable);
